### rtl/core/byte_ring_buffer_core_macros.svh
// Assertion macros for the byte ring buffer core.
// Define ASSERT_OFF to compile the checks out.
`ifndef BYTE_RING_BUFFER_CORE_MACROS_SVH
`define BYTE_RING_BUFFER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define BRB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("byte ring buffer check failed");

// Condition must never be true outside reset.
`define BRB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("byte ring buffer forbidden condition seen");

`else

`define BRB_ASSERT(label, clk, rst_n, prop)
`define BRB_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### rtl/core/brb_pkg.sv
package brb_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int LEN_W  = 6;
    localparam int CFG_W  = 4;

    localparam logic [CFG_W-1:0] CAP_LOG2_RST = CFG_W'(10);

    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

### rtl/core/brb_store.sv
module brb_store
    import brb_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [BYTE_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [BYTE_W-1:0]        o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/byte_ring_buffer_core.sv
// Byte FIFO held in a power-of-two ring of DEPTH bytes (DEPTH must be a power of two).
// Input channel: i_in_valid / o_in_stall with kind, byte_in and length; a transaction
// is one operation: write byte, read, peek, discard or clear.
// Output channel: o_out_valid / i_out_stall; each transaction carries one result
// (byte_out, has_byte, moved, used, last). A read or peek that delivers n bytes gives
// n results with last on the final one; every other operation gives one result.
// Configuration: i_cfg_valid / o_cfg_ready with capacity_log2; ready is always high.
// Write only while idle and follow a capacity change with a clear.
// A single-result operation's result is registered in the cycle after acceptance;
// the first byte of a read or peek passes the memory's read data register, then the
// output register. Write, discard and clear are taken back to back while the output
// register frees. Bursts use the single read port of the ring memory (one byte per
// cycle unless stalled, read data registered). No new operation is taken in a burst.
// Reset (synchronous, active low) empties the ring, zeroes both pointers and sets
// capacity_log2 to 10; the memory itself is not cleared and needs no sweep.
// Receiver stall: the output register holds its result; a burst pauses without
// issuing further memory reads and the input stays stalled until the register frees.
`include "byte_ring_buffer_core_macros.svh"

module byte_ring_buffer_core
    import brb_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_W-1:0]           i_cfg_data,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [KIND_W-1:0]          i_in_kind,
    input  logic [BYTE_W-1:0]          i_in_byte_in,
    input  logic [LEN_W-1:0]           i_in_length,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [BYTE_W-1:0]          o_out_byte_out,
    output logic                       o_out_has_byte,
    output logic [LEN_W-1:0]           o_out_moved,
    output logic [$clog2(DEPTH+1)-1:0] o_out_used,
    output logic                       o_out_last
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int BURST_W = $clog2(MAX_BURST + 1);
    localparam int CMP_A   = (FILL_W > BURST_W) ? FILL_W : BURST_W;
    localparam int CMP_W   = (CMP_A > LEN_W) ? CMP_A : LEN_W;

    localparam logic [CFG_W:0]   PTR_W_C  = (CFG_W + 1)'(PTR_W);
    localparam logic [CMP_W-1:0] MAX_REQ  = CMP_W'(MAX_BURST);
    localparam logic [FILL_W-1:0] FULL_CAP = FILL_W'(DEPTH);

    // Sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RD   = 1'b1;

    logic                r_state,     n_state;
    logic [CFG_W-1:0]    r_cap_log2;
    logic [PTR_W-1:0]    r_wr_ptr,    n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr,    n_rd_ptr;
    logic [FILL_W-1:0]   r_fill,      n_fill;
    logic [PTR_W-1:0]    r_burst_ptr, n_burst_ptr;
    logic [BURST_W-1:0]  r_left,      n_left;
    logic [BURST_W-1:0]  r_moved,     n_moved;

    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte,  n_out_byte;
    logic                r_out_has,   n_out_has;
    logic [LEN_W-1:0]    r_out_moved, n_out_moved;
    logic [FILL_W-1:0]   r_out_used,  n_out_used;
    logic                r_out_last,  n_out_last;

    logic                in_accept;
    logic                out_free;
    logic                cap_sat;
    logic [FILL_W-1:0]   cap;
    logic [PTR_W-1:0]    mask;
    logic [CMP_W-1:0]    req;
    logic [CMP_W-1:0]    fill_x;
    logic [CMP_W-1:0]    avail_n;
    logic [FILL_W-1:0]   avail_fill;
    logic [BURST_W-1:0]  avail_burst;

    t_mem_ctl            mem_ctl;
    logic [PTR_W-1:0]    mem_waddr;
    logic [PTR_W-1:0]    mem_raddr;
    logic [BYTE_W-1:0]   mem_rdata;

    brb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (i_in_byte_in),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_cfg_ready = 1'b1;

    // The output register frees when it is empty or taken this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Capacity in use saturates at DEPTH; the mask wraps pointers into it.
    assign cap_sat = ({1'b0, r_cap_log2} >= PTR_W_C);
    assign cap     = cap_sat ? FULL_CAP : (FILL_W'(1) << r_cap_log2);
    assign mask    = PTR_W'(cap - FILL_W'(1));

    // Bytes available to read, peek or discard: clamp the request, then the fill.
    assign fill_x      = CMP_W'(r_fill);
    assign req         = (CMP_W'(i_in_length) > MAX_REQ) ? MAX_REQ : CMP_W'(i_in_length);
    assign avail_n     = (req < fill_x) ? req : fill_x;
    assign avail_fill  = FILL_W'(avail_n);
    assign avail_burst = BURST_W'(avail_n);

    always_comb begin
        logic             single;
        logic [LEN_W-1:0] single_moved;

        single       = 1'b0;
        single_moved = '0;

        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_fill      = r_fill;
        n_burst_ptr = r_burst_ptr;
        n_left      = r_left;
        n_moved     = r_moved;

        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_out_has   = r_out_has;
        n_out_moved = r_out_moved;
        n_out_used  = r_out_used;
        n_out_last  = r_out_last;

        mem_ctl   = '0;
        mem_waddr = r_wr_ptr & mask;
        mem_raddr = (r_state == ST_IDLE) ? (r_rd_ptr & mask) : (r_burst_ptr & mask);

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (i_in_kind)
                        KIND_WRITE: begin
                            single = 1'b1;
                            // Drop the byte when the ring is full.
                            if (r_fill < cap) begin
                                mem_ctl.wr_en = 1'b1;
                                n_wr_ptr      = r_wr_ptr + PTR_W'(1);
                                n_fill        = r_fill + FILL_W'(1);
                                single_moved  = LEN_W'(1);
                            end
                        end
                        KIND_READ, KIND_PEEK: begin
                            if (avail_n == '0) begin
                                single = 1'b1;
                            end else begin
                                // Fetch the oldest byte now; results follow in ST_RD.
                                mem_ctl.rd_en = 1'b1;
                                n_burst_ptr   = r_rd_ptr + PTR_W'(1);
                                n_left        = avail_burst - BURST_W'(1);
                                n_moved       = avail_burst;
                                n_state       = ST_RD;
                                if (i_in_kind == KIND_READ) begin
                                    n_rd_ptr = r_rd_ptr + PTR_W'(avail_fill);
                                    n_fill   = r_fill - avail_fill;
                                end
                            end
                        end
                        KIND_DISCARD: begin
                            single       = 1'b1;
                            n_rd_ptr     = r_rd_ptr + PTR_W'(avail_fill);
                            n_fill       = r_fill - avail_fill;
                            single_moved = LEN_W'(avail_burst);
                        end
                        KIND_CLEAR: begin
                            single   = 1'b1;
                            n_wr_ptr = '0;
                            n_rd_ptr = '0;
                            n_fill   = '0;
                        end
                        default: begin
                            single = 1'b1;
                        end
                    endcase

                    if (single) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = '0;
                        n_out_has   = 1'b0;
                        n_out_moved = single_moved;
                        n_out_used  = n_fill;
                        n_out_last  = 1'b1;
                    end
                end
            end
            ST_RD: begin
                // The read data register holds the next byte; pass it on when free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = mem_rdata;
                    n_out_has   = 1'b1;
                    n_out_moved = LEN_W'(r_moved);
                    n_out_used  = r_fill;
                    n_out_last  = (r_left == '0);
                    if (r_left != '0) begin
                        mem_ctl.rd_en = 1'b1;
                        n_burst_ptr   = r_burst_ptr + PTR_W'(1);
                        n_left        = r_left - BURST_W'(1);
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap_log2  <= CAP_LOG2_RST;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap_log2 <= i_cfg_data;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_burst_ptr <= n_burst_ptr;
        r_left      <= n_left;
        r_moved     <= n_moved;
        r_out_byte  <= n_out_byte;
        r_out_has   <= n_out_has;
        r_out_moved <= n_out_moved;
        r_out_used  <= n_out_used;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte_out = r_out_byte;
    assign o_out_has_byte = r_out_has;
    assign o_out_moved    = r_out_moved;
    assign o_out_used     = r_out_used;
    assign o_out_last     = r_out_last;

    // No ring write may land while a burst is reading the ring.
    `BRB_ASSERT_NEVER(a_no_write_in_burst, i_clk, i_rst_n, (r_state == ST_RD) && mem_ctl.wr_en)
    // The fill level never passes the physical depth.
    `BRB_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FULL_CAP)
    // A result without a byte always closes its transaction.
    `BRB_ASSERT(a_single_last, i_clk, i_rst_n, (o_out_valid && !o_out_has_byte) |-> o_out_last)
    // A delivered byte always belongs to a nonempty burst.
    `BRB_ASSERT(a_byte_moved, i_clk, i_rst_n, (o_out_valid && o_out_has_byte) |-> (o_out_moved != '0))

endmodule
